// File: src/psdf_pkg.sv
package psdf_pkg;

  localparam int VALUE_W       = 32;
  localparam int NUM_DIGITS    = 10;
  localparam int BCD_W         = 4 * NUM_DIGITS;
  localparam int BIT_CNT_W     = $clog2(VALUE_W);
  localparam int DIGIT_CNT_W   = 4;
  localparam int CNT_W         = 7;
  localparam int MAX_WIDTH     = 64;
  localparam int MAX_PRECISION = 63;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  typedef enum logic [1:0] {
    BCD_IDLE,
    BCD_CONV,
    BCD_NORM,
    BCD_DONE
  } bcd_state_t;

  typedef enum logic [1:0] {
    FMT_IDLE,
    FMT_CONV,
    FMT_SETUP,
    FMT_EMIT
  } fmt_state_t;

  typedef struct packed {
    logic                   done;
    logic [DIGIT_CNT_W-1:0] ndig;
  } bcd_status_t;

endpackage

// File: src/psdf_bcd.sv
module psdf_bcd
  import psdf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VALUE_W-1:0] mag,
  input  logic               pop,
  output bcd_status_t        status,
  output logic [3:0]         top_digit
);

  bcd_state_t             state_r, state_nxt;
  logic [VALUE_W-1:0]     bin_r, bin_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [BCD_W-1:0]       adj;
  logic [BIT_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIGIT_CNT_W-1:0] ndig_r, ndig_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BCD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    cnt_r  <= cnt_nxt;
    ndig_r <= ndig_nxt;
  end

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    ndig_nxt  = ndig_r;
    case (state_r)
      BCD_CONV: begin
        bcd_nxt = {adj[BCD_W-2:0], bin_r[VALUE_W-1]};
        bin_nxt = {bin_r[VALUE_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == BIT_CNT_W'(VALUE_W - 1)) begin
          state_nxt = BCD_NORM;
        end
      end
      BCD_NORM: begin
        if (ndig_r > DIGIT_CNT_W'(1) && bcd_r[BCD_W-1 -: 4] == 4'd0) begin
          bcd_nxt  = {bcd_r[BCD_W-5:0], 4'd0};
          ndig_nxt = ndig_r - 1'b1;
        end else begin
          state_nxt = BCD_DONE;
        end
      end
      BCD_DONE: begin
        if (pop) begin
          bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
        end
      end
      default: begin
      end
    endcase
    if (start) begin
      state_nxt = BCD_CONV;
      bin_nxt   = mag;
      bcd_nxt   = '0;
      cnt_nxt   = '0;
      ndig_nxt  = DIGIT_CNT_W'(NUM_DIGITS);
    end
  end

  assign status.done = (state_r == BCD_DONE);
  assign status.ndig = ndig_r;
  assign top_digit   = bcd_r[BCD_W-1 -: 4];

endmodule

// File: src/padded_signed_decimal_formatter.sv
// Formats one signed 32-bit value per item as the characters of a printf %d
// conversion with field width, justification and optional precision, one
// character per output item, the final one flagged by out_last with the total
// count. Each item is accepted, converted bit-serially from binary to BCD,
// stripped of up to nine leading zero digits, handed over and sized into its
// fields, and then emitted as characters at one per cycle when the output is
// not stalled. A conversion that emits nothing gives a single item with
// out_char_valid low. A new item is accepted only when the previous
// conversion has handed its last character to the output register.
module padded_signed_decimal_formatter
  import psdf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        in_value,
  input  logic [6:0]         in_width,
  input  logic               in_left_justify,
  input  logic [6:0]         in_precision,
  input  logic               in_precision_given,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_char,
  output logic               out_char_valid,
  output logic               out_last,
  output logic [6:0]         out_char_count
);

  fmt_state_t             state_r, state_nxt;
  logic                   neg_r, neg_nxt;
  logic                   left_r, left_nxt;
  logic                   supp_r, supp_nxt;
  logic [CNT_W-1:0]       width_r, width_nxt;
  logic [CNT_W-1:0]       prec_r, prec_nxt;
  logic [CNT_W-1:0]       pre_r, pre_nxt;
  logic [CNT_W-1:0]       post_r, post_nxt;
  logic                   sign_r, sign_nxt;
  logic [CNT_W-1:0]       zeros_r, zeros_nxt;
  logic [DIGIT_CNT_W-1:0] dig_r, dig_nxt;
  logic [CNT_W-1:0]       rem_r, rem_nxt;
  logic [CNT_W-1:0]       total_r, total_nxt;
  logic                   ovalid_r, ovalid_nxt;
  logic [7:0]             ochar_r, ochar_nxt;
  logic                   ocv_r, ocv_nxt;
  logic                   olast_r, olast_nxt;
  logic [CNT_W-1:0]       ocount_r, ocount_nxt;

  logic                   accept;
  logic                   bcd_start;
  logic                   pop;
  logic [VALUE_W-1:0]     mag;
  bcd_status_t            bcd_status;
  logic [3:0]             top_digit;
  logic [CNT_W-1:0]       ndig_w, zeros_w, body_w, spaces_w;
  logic                   out_free;

  psdf_bcd u_bcd (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (bcd_start),
    .mag       (mag),
    .pop       (pop),
    .status    (bcd_status),
    .top_digit (top_digit)
  );

  assign in_stall  = (state_r != FMT_IDLE);
  assign accept    = in_valid && !in_stall;
  assign bcd_start = accept;
  assign mag       = in_value[31] ? (32'd0 - in_value) : in_value;
  assign out_free  = !ovalid_r || !out_stall;

  assign ndig_w   = CNT_W'(bcd_status.ndig);
  assign zeros_w  = (prec_r > ndig_w) ? (prec_r - ndig_w) : '0;
  assign body_w   = ndig_w + zeros_w + CNT_W'(neg_r);
  assign spaces_w = (width_r > body_w) ? (width_r - body_w) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= FMT_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
    neg_r    <= neg_nxt;
    left_r   <= left_nxt;
    supp_r   <= supp_nxt;
    width_r  <= width_nxt;
    prec_r   <= prec_nxt;
    pre_r    <= pre_nxt;
    post_r   <= post_nxt;
    sign_r   <= sign_nxt;
    zeros_r  <= zeros_nxt;
    dig_r    <= dig_nxt;
    rem_r    <= rem_nxt;
    total_r  <= total_nxt;
    ochar_r  <= ochar_nxt;
    ocv_r    <= ocv_nxt;
    olast_r  <= olast_nxt;
    ocount_r <= ocount_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    neg_nxt    = neg_r;
    left_nxt   = left_r;
    supp_nxt   = supp_r;
    width_nxt  = width_r;
    prec_nxt   = prec_r;
    pre_nxt    = pre_r;
    post_nxt   = post_r;
    sign_nxt   = sign_r;
    zeros_nxt  = zeros_r;
    dig_nxt    = dig_r;
    rem_nxt    = rem_r;
    total_nxt  = total_r;
    ovalid_nxt = ovalid_r && out_stall;
    ochar_nxt  = ochar_r;
    ocv_nxt    = ocv_r;
    olast_nxt  = olast_r;
    ocount_nxt = ocount_r;
    pop        = 1'b0;

    case (state_r)
      FMT_IDLE: begin
        if (accept) begin
          neg_nxt   = in_value[31];
          left_nxt  = in_left_justify;
          supp_nxt  = in_precision_given && (in_precision == 7'd0) && (in_value == 32'd0);
          width_nxt = (in_width > CNT_W'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : in_width;
          if (in_precision[6]) begin
            prec_nxt = '0;
          end else if (in_precision > CNT_W'(MAX_PRECISION)) begin
            prec_nxt = CNT_W'(MAX_PRECISION);
          end else begin
            prec_nxt = in_precision;
          end
          state_nxt = FMT_CONV;
        end
      end
      FMT_CONV: begin
        if (bcd_status.done) begin
          state_nxt = FMT_SETUP;
        end
      end
      FMT_SETUP: begin
        if (supp_r) begin
          sign_nxt  = 1'b0;
          zeros_nxt = '0;
          dig_nxt   = '0;
          pre_nxt   = left_r ? '0 : width_r;
          post_nxt  = left_r ? width_r : '0;
          rem_nxt   = width_r;
        end else begin
          sign_nxt  = neg_r;
          zeros_nxt = zeros_w;
          dig_nxt   = bcd_status.ndig;
          pre_nxt   = left_r ? '0 : spaces_w;
          post_nxt  = left_r ? spaces_w : '0;
          rem_nxt   = body_w + spaces_w;
        end
        total_nxt = rem_nxt;
        state_nxt = FMT_EMIT;
      end
      FMT_EMIT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          if (rem_r == '0) begin
            ochar_nxt  = 8'd0;
            ocv_nxt    = 1'b0;
            olast_nxt  = 1'b1;
            ocount_nxt = '0;
            state_nxt  = FMT_IDLE;
          end else begin
            ocv_nxt = 1'b1;
            if (pre_r != '0) begin
              ochar_nxt = CHAR_SPACE;
              pre_nxt   = pre_r - 1'b1;
            end else if (sign_r) begin
              ochar_nxt = CHAR_MINUS;
              sign_nxt  = 1'b0;
            end else if (zeros_r != '0) begin
              ochar_nxt = CHAR_ZERO;
              zeros_nxt = zeros_r - 1'b1;
            end else if (dig_r != '0) begin
              ochar_nxt = CHAR_ZERO + {4'd0, top_digit};
              dig_nxt   = dig_r - 1'b1;
              pop       = 1'b1;
            end else begin
              ochar_nxt = CHAR_SPACE;
              post_nxt  = post_r - 1'b1;
            end
            rem_nxt = rem_r - 1'b1;
            if (rem_r == CNT_W'(1)) begin
              olast_nxt  = 1'b1;
              ocount_nxt = total_r;
              state_nxt  = FMT_IDLE;
            end else begin
              olast_nxt  = 1'b0;
              ocount_nxt = '0;
            end
          end
        end
      end
      default: begin
        state_nxt = FMT_IDLE;
      end
    endcase
  end

  assign out_valid      = ovalid_r;
  assign out_char       = ochar_r;
  assign out_char_valid = ocv_r;
  assign out_last       = olast_r;
  assign out_char_count = ocount_r;

endmodule

// File: dv/tb_padded_signed_decimal_formatter.sv
module tb_padded_signed_decimal_formatter
  import psdf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HANG_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 120;
  localparam int RANDOM_ITEMS = 450;
  localparam int CALM_ITEMS  = 60;

  typedef struct {
    logic [7:0] ch;
    logic       ch_valid;
    logic       last;
    logic [6:0] count;
  } fmt_char_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [31:0] in_value;
  logic [6:0] in_width;
  logic       in_left_justify;
  logic [6:0] in_precision;
  logic       in_precision_given;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_char;
  logic       out_char_valid;
  logic       out_last;
  logic [6:0] out_char_count;

  fmt_char_t  pending_chars[$];
  int         mismatch_count = 0;
  int         chars_seen = 0;
  int         quiet_cycles = 0;
  bit         idle_on = 1'b1;

  padded_signed_decimal_formatter dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_value           (in_value),
    .in_width           (in_width),
    .in_left_justify    (in_left_justify),
    .in_precision       (in_precision),
    .in_precision_given (in_precision_given),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_char           (out_char),
    .out_char_valid     (out_char_valid),
    .out_last           (out_last),
    .out_char_count     (out_char_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("[%0t] char %0d: %s got 0x%0h, expected 0x%0h", $realtime, chars_seen, what,
             got, want);
  endtask

  function automatic void predict_conversion(logic [31:0] value, logic [6:0] width_raw,
                                             logic left, logic [6:0] prec_raw,
                                             logic pgiven);
    int         field_w;
    int         prec;
    int         nd;
    int         zeros;
    int         spaces;
    logic       neg;
    logic [31:0] mag;
    logic [7:0] digits[10];
    logic [7:0] text[$];
    fmt_char_t  c;
    field_w = (width_raw > MAX_WIDTH) ? MAX_WIDTH : int'(width_raw);
    prec = $signed(prec_raw);
    if (prec > MAX_PRECISION) prec = MAX_PRECISION;
    neg = value[31];
    mag = neg ? -value : value;
    if (pgiven && prec == 0 && value == 32'd0) begin
      repeat (field_w) text.push_back(CHAR_SPACE);
    end else begin
      nd = 0;
      do begin
        digits[nd] = CHAR_ZERO + 8'(mag % 10);
        mag = mag / 10;
        nd++;
      end while (mag != 0);
      zeros = (prec > nd) ? prec - nd : 0;
      spaces = field_w - (nd + zeros + int'(neg));
      if (spaces < 0) spaces = 0;
      if (!left) repeat (spaces) text.push_back(CHAR_SPACE);
      if (neg) text.push_back(CHAR_MINUS);
      repeat (zeros) text.push_back(CHAR_ZERO);
      for (int i = nd - 1; i >= 0; i--) text.push_back(digits[i]);
      if (left) repeat (spaces) text.push_back(CHAR_SPACE);
    end
    if (text.size() == 0) begin
      c = '{8'd0, 1'b0, 1'b1, 7'd0};
      pending_chars.push_back(c);
    end else begin
      foreach (text[k]) begin
        c.ch = text[k];
        c.ch_valid = 1'b1;
        c.last = (k == text.size() - 1);
        c.count = c.last ? 7'(text.size()) : 7'd0;
        pending_chars.push_back(c);
      end
    end
  endfunction

  task automatic send_conversion(logic [31:0] value, logic [6:0] width, logic left,
                                 logic [6:0] prec, logic pgiven);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_value = value;
    in_width = width;
    in_left_justify = left;
    in_precision = prec;
    in_precision_given = pgiven;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_conversion(value, width, left, prec, pgiven);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        out_stall = 1'b0;
        repeat ($urandom_range(1, 30) - 1) @(negedge clk);
      end
      if (!idle_on) out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected char", 32'(out_char), 32'd0);
      end else begin
        fmt_char_t want;
        want = pending_chars.pop_front();
        if (out_char !== want.ch)
          report_mismatch("out_char", 32'(out_char), 32'(want.ch));
        if (out_char_valid !== want.ch_valid)
          report_mismatch("out_char_valid", 32'(out_char_valid), 32'(want.ch_valid));
        if (out_last !== want.last)
          report_mismatch("out_last", 32'(out_last), 32'(want.last));
        if (out_char_count !== want.count)
          report_mismatch("out_char_count", 32'(out_char_count), 32'(want.count));
      end
      chars_seen++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("FAIL padded_signed_decimal_formatter");
        $finish;
      end
    end
  end

  task automatic test_extreme_values();
    send_conversion(32'd0, 7'd0, 1'b0, 7'h7F, 1'b0);
    send_conversion(32'd1, 7'd5, 1'b0, 7'h7F, 1'b0);
    send_conversion(32'hFFFF_FFFF, 7'd5, 1'b1, 7'h7F, 1'b0);
    send_conversion(32'h7FFF_FFFF, 7'd0, 1'b0, 7'h7F, 1'b0);
    send_conversion(32'h8000_0000, 7'd0, 1'b0, 7'h7F, 1'b0);
    send_conversion(32'h8000_0000, 7'd15, 1'b1, 7'd12, 1'b1);
    send_conversion(32'd1_000_000_000, 7'd11, 1'b0, 7'd3, 1'b1);
    send_conversion(-32'sd42, 7'd8, 1'b0, 7'd5, 1'b1);
    send_conversion(32'd7, 7'd64, 1'b1, 7'h7F, 1'b0);
  endtask

  task automatic test_zero_suppression();
    send_conversion(32'd0, 7'd0, 1'b0, 7'd0, 1'b1);
    send_conversion(32'd0, 7'd0, 1'b1, 7'd0, 1'b1);
    send_conversion(32'd0, 7'd6, 1'b0, 7'd0, 1'b1);
    send_conversion(32'd0, 7'd6, 1'b1, 7'd0, 1'b1);
    send_conversion(32'd0, 7'd4, 1'b1, 7'd0, 1'b0);
    send_conversion(32'd0, 7'd0, 1'b0, 7'd4, 1'b0);
    send_conversion(32'd5, 7'd3, 1'b0, 7'd0, 1'b1);
  endtask

  task automatic test_saturation();
    send_conversion(32'd123, 7'd127, 1'b0, 7'h7F, 1'b0);
    send_conversion(-32'sd9, 7'd65, 1'b1, 7'h40, 1'b1);
    send_conversion(32'd9, 7'd0, 1'b0, 7'd63, 1'b1);
    send_conversion(32'h8000_0000, 7'd127, 1'b1, 7'd63, 1'b1);
    send_conversion(32'd0, 7'd127, 1'b0, 7'd0, 1'b1);
    send_conversion(32'd31, 7'd40, 1'b0, 7'd62, 1'b0);
  endtask

  task automatic test_random_conversions(int count);
    logic [31:0] v;
    logic [6:0]  w;
    logic [6:0]  p;
    logic        lj;
    logic        pg;
    int unsigned pw;
    for (int n = 0; n < count; n++) begin
      if (n == count - CALM_ITEMS) idle_on = 1'b0;
      case ($urandom_range(0, 6))
        0, 1: v = $urandom;
        2: v = $urandom_range(0, 999);
        3: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        4: begin
          pw = 1;
          repeat ($urandom_range(0, 9)) pw = pw * 10;
          v = pw + $urandom_range(0, 2) - 1;
        end
        5: v = 32'd0;
        default: v = $urandom >> $urandom_range(0, 31);
      endcase
      if ($urandom_range(0, 1) == 1) v = -v;
      case ($urandom_range(0, 7))
        0: w = 7'($urandom_range(0, 127));
        1: w = 7'($urandom_range(MAX_WIDTH - 4, MAX_WIDTH));
        default: w = 7'($urandom_range(0, 16));
      endcase
      case ($urandom_range(0, 5))
        0, 1: p = 7'h7F;
        2: p = 7'($urandom_range(0, 127));
        3: p = 7'd0;
        default: p = 7'($urandom_range(0, 12));
      endcase
      lj = 1'($urandom_range(0, 1));
      pg = p[6] ? ($urandom_range(0, 4) == 0) : ($urandom_range(0, 4) != 0);
      send_conversion(v, w, lj, p, pg);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    in_width = '0;
    in_left_justify = 1'b0;
    in_precision = '0;
    in_precision_given = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_extreme_values();
    test_zero_suppression();
    test_saturation();
    test_random_conversions(RANDOM_ITEMS);

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && pending_chars.size() == 0) begin
      $display("PASS padded_signed_decimal_formatter");
    end else begin
      $display("FAIL padded_signed_decimal_formatter");
    end
    $finish;
  end

endmodule
